[hw/rtl/lsd_pkg.sv]
// Shared types and constants for the laser spot detector.
// Used by lsd_detect, laser_spot_detector_core and lsd_checker; depends on nothing.
`timescale 1ns / 1ps

package lsd_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int LIMIT_W    = 14;
    localparam int OFFSET_W   = 8;
    localparam int SETTLE_W   = 15;
    localparam int HIT_W      = 9;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LIMIT_POS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LIMIT_NEG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_LIMIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_HIGH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OFFSET      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_INITIAL  = 3'd7;

    // Register reset values.
    localparam logic [7:0]          RST_HIT_THRESHOLD   = 8'd10;
    localparam logic [LIMIT_W-1:0]  RST_LIGHT_LIMIT_POS = 14'd200;
    localparam logic [LIMIT_W-1:0]  RST_LIGHT_LIMIT_NEG = 14'd200;
    localparam logic [LIMIT_W-1:0]  RST_RISE_LIMIT      = 14'd100;
    localparam logic [LIMIT_W-1:0]  RST_DETECT_LOW      = 14'd50;
    localparam logic [LIMIT_W-1:0]  RST_DETECT_HIGH     = 14'd2000;
    localparam logic [OFFSET_W-1:0] RST_MAX_OFFSET      = 8'd255;
    localparam logic [SETTLE_W-1:0] RST_SETTLE_INITIAL  = 15'd8;

    // Average band limits, in converter counts, for each band shift.
    localparam int BAND_LOW_MINUS  = 100;
    localparam int BAND_LOW_NONE   = 200;
    localparam int BAND_LOW_PLUS   = 300;
    localparam int BAND_HIGH_MINUS = 800;
    localparam int BAND_HIGH_NONE  = 900;
    localparam int BAND_HIGH_PLUS  = 1000;

    // Ambient settle time is the hit threshold times this many items.
    localparam logic [SETTLE_W-1:0] SETTLE_SCALE = 15'd100;

    typedef enum logic [1:0] {
        BAND_NONE,
        BAND_PLUS,
        BAND_MINUS
    } band_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] detector_sample;
        logic [SAMPLE_W-1:0] light_sample;
    } sample_t;

    typedef struct packed {
        logic                detected;
        logic                led_on;
        logic [OFFSET_W-1:0] drive_offset;
        logic                offset_load;
        logic                initializing;
    } result_t;

    typedef struct packed {
        logic [7:0]          hit_threshold;
        logic [LIMIT_W-1:0]  light_limit_pos;
        logic [LIMIT_W-1:0]  light_limit_neg;
        logic [LIMIT_W-1:0]  rise_limit;
        logic [LIMIT_W-1:0]  detect_low;
        logic [LIMIT_W-1:0]  detect_high;
        logic [OFFSET_W-1:0] max_offset;
        logic [SETTLE_W-1:0] settle_initial;
    } cfg_t;

endpackage

[hw/rtl/lsd_detect.sv]
// Moving-sum windows, baselines and the detection rules of the laser spot detector.
// Depends on lsd_pkg; instantiated by laser_spot_detector_core.
`timescale 1ns / 1ps

module lsd_detect #(
    parameter int WINDOW_LEN = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  lsd_pkg::sample_t sample,
    input  lsd_pkg::cfg_t    cfg,
    output lsd_pkg::result_t result
);

    localparam int SUM_W  = $clog2(WINDOW_LEN * 1023 + 1);
    localparam int CMP_W  = (SUM_W > lsd_pkg::LIMIT_W) ? SUM_W : lsd_pkg::LIMIT_W;
    localparam int FILL_W = $clog2(WINDOW_LEN);

    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_LEN - 1);

    // The average test is done on the sum: avg < T is sum < T*W, avg > T is sum >= (T+1)*W.
    localparam logic [SUM_W-1:0] LOW_MINUS  = SUM_W'(lsd_pkg::BAND_LOW_MINUS * WINDOW_LEN);
    localparam logic [SUM_W-1:0] LOW_NONE   = SUM_W'(lsd_pkg::BAND_LOW_NONE * WINDOW_LEN);
    localparam logic [SUM_W-1:0] LOW_PLUS   = SUM_W'(lsd_pkg::BAND_LOW_PLUS * WINDOW_LEN);
    localparam logic [SUM_W-1:0] HIGH_MINUS = SUM_W'((lsd_pkg::BAND_HIGH_MINUS + 1) * WINDOW_LEN);
    localparam logic [SUM_W-1:0] HIGH_NONE  = SUM_W'((lsd_pkg::BAND_HIGH_NONE + 1) * WINDOW_LEN);
    localparam logic [SUM_W-1:0] HIGH_PLUS  = SUM_W'((lsd_pkg::BAND_HIGH_PLUS + 1) * WINDOW_LEN);

    logic [lsd_pkg::SAMPLE_W-1:0] det_win_reg   [WINDOW_LEN];
    logic [lsd_pkg::SAMPLE_W-1:0] light_win_reg [WINDOW_LEN];

    logic [SUM_W-1:0]             det_sum_reg, det_sum_next;
    logic [SUM_W-1:0]             light_sum_reg, light_sum_next;
    logic [SUM_W-1:0]             det_base_reg, det_base_next;
    logic [SUM_W-1:0]             light_base_reg, light_base_next;
    logic [lsd_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    lsd_pkg::band_t               band_reg, band_next;
    logic [lsd_pkg::SETTLE_W-1:0] settle_reg, settle_next;
    logic [lsd_pkg::HIT_W-1:0]    hit_reg, hit_next;
    logic                         init_reg, init_next;
    logic [FILL_W-1:0]            fill_reg, fill_next;
    logic                         led_reg, led_next;

    logic [SUM_W-1:0]             det_in, light_in;
    logic [SUM_W-1:0]             low_thr, high_thr;
    logic                         low_exit, high_exit;
    logic [CMP_W-1:0]             light_rise, light_fall, det_rise, det_dip;
    logic                         light_up, light_down, det_up;
    logic [lsd_pkg::HIT_W-1:0]    hit_inc;
    logic [lsd_pkg::HIT_W-1:0]    hit_limit;

    assign det_in    = SUM_W'(sample.detector_sample);
    assign light_in  = SUM_W'(sample.light_sample);
    assign hit_limit = lsd_pkg::HIT_W'(cfg.hit_threshold);

    always_comb
    begin
        unique case (band_reg)
            lsd_pkg::BAND_PLUS:
            begin
                low_thr  = LOW_PLUS;
                high_thr = HIGH_PLUS;
            end
            lsd_pkg::BAND_MINUS:
            begin
                low_thr  = LOW_MINUS;
                high_thr = HIGH_MINUS;
            end
            default:
            begin
                low_thr  = LOW_NONE;
                high_thr = HIGH_NONE;
            end
        endcase
    end

    always_comb
    begin
        det_sum_next    = det_sum_reg;
        light_sum_next  = light_sum_reg;
        det_base_next   = det_base_reg;
        light_base_next = light_base_reg;
        offset_next     = offset_reg;
        band_next       = band_reg;
        settle_next     = settle_reg;
        hit_next        = hit_reg;
        init_next       = init_reg;
        fill_next       = fill_reg;
        led_next        = led_reg;

        result.detected     = 1'b0;
        result.offset_load  = 1'b0;
        result.drive_offset = offset_reg;
        result.initializing = init_reg;

        low_exit   = 1'b0;
        high_exit  = 1'b0;
        light_up   = 1'b0;
        light_down = 1'b0;
        det_up     = 1'b0;
        light_rise = '0;
        light_fall = '0;
        det_rise   = '0;
        det_dip    = '0;
        hit_inc    = hit_reg;

        if (init_reg)
        begin
            // The first refill item restarts both sums and reloads the sensor offset.
            if (fill_reg == '0)
            begin
                result.offset_load = 1'b1;
                det_sum_next       = det_in;
                light_sum_next     = light_in;
            end
            else
            begin
                det_sum_next   = det_sum_reg + det_in;
                light_sum_next = light_sum_reg + light_in;
            end

            if (fill_reg == FILL_LAST)
            begin
                det_base_next   = det_sum_next;
                light_base_next = light_sum_next;
                hit_next        = '0;
                init_next       = 1'b0;
                fill_next       = '0;
                settle_next     = cfg.settle_initial;
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        else
        begin
            det_sum_next   = det_sum_reg - SUM_W'(det_win_reg[0]) + det_in;
            light_sum_next = light_sum_reg - SUM_W'(light_win_reg[0]) + light_in;

            low_exit  = (det_sum_next < low_thr) && (offset_reg != cfg.max_offset);
            high_exit = (det_sum_next >= high_thr) && (offset_reg != '0);

            light_up   = light_sum_next > light_base_reg;
            light_down = light_base_reg > light_sum_next;
            light_rise = CMP_W'(light_sum_next - light_base_reg);
            light_fall = CMP_W'(light_base_reg - light_sum_next);
            det_up     = det_sum_next > det_base_reg;
            det_rise   = CMP_W'(det_sum_next - det_base_reg);
            det_dip    = CMP_W'(det_base_reg - det_sum_next);
            hit_inc    = (hit_reg <= hit_limit) ? hit_reg + lsd_pkg::HIT_W'(1) : hit_reg;

            priority if (low_exit || high_exit)
            begin
                result.offset_load = 1'b1;
                init_next          = 1'b1;
                fill_next          = '0;
                priority if (band_reg == lsd_pkg::BAND_NONE)
                begin
                    // First exit: shift out a zero offset without stepping.
                    result.drive_offset = '0;
                    band_next           = lsd_pkg::BAND_PLUS;
                end
                else if (high_exit)
                begin
                    offset_next         = offset_reg - lsd_pkg::OFFSET_W'(1);
                    result.drive_offset = offset_next;
                    band_next           = lsd_pkg::BAND_MINUS;
                end
                else
                begin
                    offset_next = (offset_reg != '1) ?
                                  offset_reg + lsd_pkg::OFFSET_W'(1) : offset_reg;
                    result.drive_offset = offset_next;
                    band_next           = lsd_pkg::BAND_PLUS;
                end
            end
            else if ((light_up && light_rise > CMP_W'(cfg.light_limit_pos)) ||
                     (light_down && light_fall > CMP_W'(cfg.light_limit_neg)))
            begin
                det_base_next   = det_sum_next;
                light_base_next = light_sum_next;
                settle_next     = lsd_pkg::SETTLE_W'({7'd0, cfg.hit_threshold} *
                                                     lsd_pkg::SETTLE_SCALE);
            end
            else if (settle_reg > lsd_pkg::SETTLE_W'(1))
            begin
                settle_next = settle_reg - lsd_pkg::SETTLE_W'(1);
            end
            else if (settle_reg == lsd_pkg::SETTLE_W'(1))
            begin
                hit_next        = '0;
                settle_next     = '0;
                det_base_next   = det_sum_next;
                light_base_next = light_sum_next;
            end
            else if (det_up && det_rise > CMP_W'(cfg.rise_limit))
            begin
                det_base_next   = det_sum_next;
                light_base_next = light_sum_next;
            end
            else if (!det_up &&
                     det_dip > CMP_W'(cfg.detect_low) && det_dip < CMP_W'(cfg.detect_high))
            begin
                hit_next = hit_inc;
                if (hit_inc > hit_limit)
                begin
                    led_next        = 1'b1;
                    result.detected = 1'b1;
                end
                else
                begin
                    led_next = 1'b0;
                end
            end
            else
            begin
                hit_next = '0;
                led_next = 1'b0;
            end
        end

        result.led_on = led_next;
    end

    // Both windows shift one place per item; a full refill leaves them in arrival order.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < WINDOW_LEN - 1; i++)
            begin
                det_win_reg[i]   <= det_win_reg[i + 1];
                light_win_reg[i] <= light_win_reg[i + 1];
            end
            det_win_reg[WINDOW_LEN - 1]   <= sample.detector_sample;
            light_win_reg[WINDOW_LEN - 1] <= sample.light_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_sum_reg    <= '0;
            light_sum_reg  <= '0;
            det_base_reg   <= '0;
            light_base_reg <= '0;
            offset_reg     <= '0;
            band_reg       <= lsd_pkg::BAND_NONE;
            settle_reg     <= '0;
            hit_reg        <= '0;
            init_reg       <= 1'b1;
            fill_reg       <= '0;
            led_reg        <= 1'b0;
        end
        else if (step)
        begin
            det_sum_reg    <= det_sum_next;
            light_sum_reg  <= light_sum_next;
            det_base_reg   <= det_base_next;
            light_base_reg <= light_base_next;
            offset_reg     <= offset_next;
            band_reg       <= band_next;
            settle_reg     <= settle_next;
            hit_reg        <= hit_next;
            init_reg       <= init_next;
            fill_reg       <= fill_next;
            led_reg        <= led_next;
        end
    end

endmodule

[hw/rtl/laser_spot_detector_core.sv]
// Top level of the laser spot detector: configuration registers, detection logic and result buffer.
// Depends on lsd_pkg and lsd_detect.
`timescale 1ns / 1ps

// The detector takes one sample pair per clock cycle while sample_stall is low and returns one
// result per sample pair. All window, baseline and rule updates for an item are finished
// in the cycle of its transfer, in the single pass through lsd_detect, so the next pair may
// follow at once. Results pass through an output register backed by one skid register: the
// sample channel keeps taking pairs while a single result waits, and stalls only when both
// hold results. After reset, and after every sensor offset change, the first WINDOW_LEN pairs
// refill the sample windows and return results flagged as initializing. Configuration writes
// take effect at the next edge and are meant for idle periods.
module laser_spot_detector_core #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  lsd_pkg::sample_t                 sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output lsd_pkg::result_t                 result,
    input  logic                             cfg_write,
    input  logic [lsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lsd_pkg::cfg_t    cfg_reg;
    lsd_pkg::result_t calc_result;
    lsd_pkg::result_t out_data_reg, skid_data_reg;
    logic             out_valid_reg, skid_valid_reg;
    logic             accept, out_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hit_threshold   <= lsd_pkg::RST_HIT_THRESHOLD;
            cfg_reg.light_limit_pos <= lsd_pkg::RST_LIGHT_LIMIT_POS;
            cfg_reg.light_limit_neg <= lsd_pkg::RST_LIGHT_LIMIT_NEG;
            cfg_reg.rise_limit      <= lsd_pkg::RST_RISE_LIMIT;
            cfg_reg.detect_low      <= lsd_pkg::RST_DETECT_LOW;
            cfg_reg.detect_high     <= lsd_pkg::RST_DETECT_HIGH;
            cfg_reg.max_offset      <= lsd_pkg::RST_MAX_OFFSET;
            cfg_reg.settle_initial  <= lsd_pkg::RST_SETTLE_INITIAL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lsd_pkg::CFG_HIT_THRESHOLD:   cfg_reg.hit_threshold   <= cfg_data[7:0];
                lsd_pkg::CFG_LIGHT_LIMIT_POS: cfg_reg.light_limit_pos <= cfg_data[13:0];
                lsd_pkg::CFG_LIGHT_LIMIT_NEG: cfg_reg.light_limit_neg <= cfg_data[13:0];
                lsd_pkg::CFG_RISE_LIMIT:      cfg_reg.rise_limit      <= cfg_data[13:0];
                lsd_pkg::CFG_DETECT_LOW:      cfg_reg.detect_low      <= cfg_data[13:0];
                lsd_pkg::CFG_DETECT_HIGH:     cfg_reg.detect_high     <= cfg_data[13:0];
                lsd_pkg::CFG_MAX_OFFSET:      cfg_reg.max_offset      <= cfg_data[7:0];
                lsd_pkg::CFG_SETTLE_INITIAL:  cfg_reg.settle_initial  <= cfg_data;
                default:                      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign sample_stall = skid_valid_reg;
    assign accept       = sample_valid && !skid_valid_reg;
    assign out_pop      = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    lsd_detect #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_detect (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .sample (sample),
        .cfg    (cfg_reg),
        .result (calc_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_pop)
            begin
                skid_data_reg <= calc_result;
            end
            else
            begin
                out_data_reg <= calc_result;
            end
        end
    end

endmodule

[hw/rtl/lsd_checker.sv]
// Port-level checks for laser_spot_detector_core, attached to it by the bind below.
// Depends on lsd_pkg.
`timescale 1ns / 1ps

module lsd_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_stall,
    input  logic             result_valid,
    input  logic             result_stall,
    input  lsd_pkg::result_t result
);

    // A result that is held back stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or was dropped");

    // The buffer only fills up behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
        else $error("sample channel stalled with no result waiting");

    // A confirmed hit always lights the indicator.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.detected |-> result.led_on)
        else $error("detection without indicator");

    // Items spent refilling the windows never report a hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.initializing |-> !result.detected)
        else $error("detection during window refill");

endmodule

bind laser_spot_detector_core lsd_checker u_lsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
